// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== src/trz_pkg.sv =====
// Shared types and constants of the trapezoid rule integrator.
`timescale 1ns / 1ps
package trz_pkg;
  localparam int FRAC_BITS    = 24;
  localparam int MAX_COUNT    = 65536;
  localparam int XW           = 49;   // sample abscissa width
  localparam int FW           = 48;   // function value width
  localparam int EXP_TERMS    = 14;
  localparam int CORDIC_STEPS = 30;

  localparam logic [FW-1:0] FVAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [63:0]   ACC_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic signed [XW-1:0] EXP_LIM  = 49'sd536870912;
  localparam logic signed [XW-1:0] EXP_NLIM = -49'sd536870912;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] LN2_X2    = 32'd1488522236;
  localparam logic [16:0] EXP_MQ    = 17'd94547;       // floor(2^46 / ln2_q30) - 1
  localparam logic [36:0] EXP_BIAS  = 37'd35724533664; // 48 * ln2_q30
  localparam logic [7:0]  EXP_BIASQ = 8'd48;

  // ceil(2^34 / n), n = 1..14
  localparam logic [34:0] EXP_RECIP [EXP_TERMS] = '{
    35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
    35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
    35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766,
    35'd1321528399,  35'd1227133514
  };

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  localparam logic [1:0] FN_SQUARE = 2'd0;
  localparam logic [1:0] FN_EXP    = 2'd1;
  localparam logic [1:0] FN_ATAN   = 2'd2;

  typedef struct packed {
    logic w2;    // interior sample, weight two
    logic last;  // final sample of the job
  } pt_tag_t;
endpackage

// ===== src/trz_sq.sv =====
// Square unit: |x|^2 >> FRAC_BITS, rounded, saturated.
`timescale 1ns / 1ps
module trz_sq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [trz_pkg::XW-1:0]   x,
  input  trz_pkg::pt_tag_t                in_tag,
  output logic                            out_valid,
  output logic signed [trz_pkg::FW-1:0]   fv,
  output logic                            fv_sat,
  output trz_pkg::pt_tag_t                out_tag
);
  import trz_pkg::*;

  logic [XW-1:0] xu, mag;
  logic          big;
  logic [35:0]   phh_next, phl_next, pll_next;
  logic          s1_v, s1_big;
  logic [35:0]   phh, phl, pll;
  pt_tag_t       s1_tag;
  logic [71:0]   sq;
  logic [FW-1:0] rnd;
  logic          over;

  assign xu  = x;
  assign mag = xu[XW-1] ? (~xu + 1'b1) : xu;
  assign big = |mag[XW-1:36];
  assign phh_next = mag[35:18] * mag[35:18];
  assign phl_next = mag[35:18] * mag[17:0];
  assign pll_next = mag[17:0] * mag[17:0];

  // partial products recombined, plus half an lsb for rounding
  assign sq   = (72'(phh) << 36) + (72'(phl) << 19) + 72'(pll) + (72'd1 << (FRAC_BITS - 1));
  assign rnd  = sq[FRAC_BITS +: FW];
  assign over = s1_big | (rnd > FVAL_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v      <= in_valid;
      out_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_big  <= big;
    phh     <= phh_next;
    phl     <= phl_next;
    pll     <= pll_next;
    s1_tag  <= in_tag;
    fv      <= $signed(over ? FVAL_MAX : rnd);
    fv_sat  <= over;
    out_tag <= s1_tag;
  end
endmodule

// ===== src/trz_exp.sv =====
// Exponential unit: ln2 range reduction, pipelined Taylor series, scaling.
`timescale 1ns / 1ps
module trz_exp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [trz_pkg::XW-1:0]   x,
  input  trz_pkg::pt_tag_t                in_tag,
  output logic                            out_valid,
  output logic signed [trz_pkg::FW-1:0]   fv,
  output logic                            fv_sat,
  output trz_pkg::pt_tag_t                out_tag
);
  import trz_pkg::*;

  typedef struct packed {
    logic              hi;
    logic              lo;
    pt_tag_t           tag;
    logic signed [7:0] k;
    logic [29:0]       r;
    logic [31:0]       sum;
  } ex_pl_t;

  // range reduction stages
  logic        e1_v, e2_v, e3_v, e4_v;
  logic        e1_hi, e1_lo, e2_hi, e2_lo, e3_hi, e3_lo;
  pt_tag_t     e1_tag, e2_tag, e3_tag;
  logic [36:0] e1_t, e2_t;
  logic [7:0]  e2_qe, e3_q;
  logic [31:0] e3_r0;
  ex_pl_t      e4_pl;
  logic [37:0] qp, qm;
  logic [36:0] t_next;
  logic [31:0] r0_next;
  logic [29:0] r_next;
  logic [7:0]  q_next;

  // series stages: multiply by r, then divide by the term index
  logic        m_vin  [EXP_TERMS];
  ex_pl_t      m_in   [EXP_TERMS];
  logic [30:0] m_tin  [EXP_TERMS];
  logic [60:0] mprod  [EXP_TERMS];
  logic        m_v    [EXP_TERMS];
  ex_pl_t      m_pl   [EXP_TERMS];
  logic [29:0] m_p    [EXP_TERMS];
  logic [64:0] dprod  [EXP_TERMS];
  ex_pl_t      d_nx   [EXP_TERMS];
  logic        d_v    [EXP_TERMS];
  ex_pl_t      d_pl   [EXP_TERMS];
  logic [30:0] d_term [EXP_TERMS];

  ex_pl_t               fin;
  logic signed [8:0]    sh;
  logic [6:0]           rs;
  logic [48:0]          vl;
  logic [63:0]          vr;
  logic [FW-1:0]        f_val;
  logic                 f_sat;

  assign t_next  = EXP_BIAS + {x[30:0], 6'b0};
  assign qp      = e1_t[36:16] * EXP_MQ;
  assign qm      = e2_qe * LN2_Q30;
  assign r0_next = e2_t[31:0] - qm[31:0];

  // estimate is low by at most two
  always_comb begin
    if (e3_r0 >= LN2_X2) begin
      r_next = 30'(e3_r0 - LN2_X2);
      q_next = e3_q + 8'd2;
    end else if (e3_r0 >= 32'(LN2_Q30)) begin
      r_next = 30'(e3_r0 - 32'(LN2_Q30));
      q_next = e3_q + 8'd1;
    end else begin
      r_next = e3_r0[29:0];
      q_next = e3_q;
    end
  end

  always_comb begin
    for (int j = 0; j < EXP_TERMS; j++) begin
      if (j == 0) begin
        m_vin[j] = e4_v;
        m_in[j]  = e4_pl;
        m_tin[j] = 31'h4000_0000;
      end else begin
        m_vin[j] = d_v[j-1];
        m_in[j]  = d_pl[j-1];
        m_tin[j] = d_term[j-1];
      end
      mprod[j]    = m_tin[j] * m_in[j].r;
      dprod[j]    = m_p[j] * EXP_RECIP[j];
      d_nx[j]     = m_pl[j];
      d_nx[j].sum = m_pl[j].sum + 32'(dprod[j][64:34]);
    end
  end

  // scale e^r by 2^k into Q.FRAC_BITS
  always_comb begin
    fin   = d_pl[EXP_TERMS-1];
    sh    = 9'(fin.k) - 9'sd6;
    rs    = 7'(-sh);
    vl    = 49'(fin.sum) << sh[4:0];
    vr    = (64'(fin.sum) + (64'd1 << (rs - 7'd1))) >> rs;
    f_sat = 1'b0;
    f_val = '0;
    if (fin.hi) begin
      f_sat = 1'b1;
      f_val = FVAL_MAX;
    end else if (fin.lo) begin
      f_val = '0;
    end else if (!sh[8]) begin
      if (sh > 9'sd16 || vl > 49'(FVAL_MAX)) begin
        f_sat = 1'b1;
        f_val = FVAL_MAX;
      end else begin
        f_val = vl[FW-1:0];
      end
    end else if (rs <= 7'd62) begin
      f_val = vr[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < EXP_TERMS; j++) begin
        m_v[j] <= 1'b0;
        d_v[j] <= 1'b0;
      end
    end else begin
      e1_v <= in_valid;
      e2_v <= e1_v;
      e3_v <= e2_v;
      e4_v <= e3_v;
      for (int j = 0; j < EXP_TERMS; j++) begin
        m_v[j] <= m_vin[j];
        d_v[j] <= m_v[j];
      end
      out_valid <= d_v[EXP_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    e1_hi  <= x > EXP_LIM;
    e1_lo  <= x < EXP_NLIM;
    e1_tag <= in_tag;
    e1_t   <= t_next;
    e2_hi  <= e1_hi;
    e2_lo  <= e1_lo;
    e2_tag <= e1_tag;
    e2_t   <= e1_t;
    e2_qe  <= qp[37:30];
    e3_hi  <= e2_hi;
    e3_lo  <= e2_lo;
    e3_tag <= e2_tag;
    e3_q   <= e2_qe;
    e3_r0  <= r0_next;
    e4_pl.hi  <= e3_hi;
    e4_pl.lo  <= e3_lo;
    e4_pl.tag <= e3_tag;
    e4_pl.k   <= $signed(q_next - EXP_BIASQ);
    e4_pl.r   <= r_next;
    e4_pl.sum <= 32'h4000_0000;
    for (int j = 0; j < EXP_TERMS; j++) begin
      m_pl[j]   <= m_in[j];
      m_p[j]    <= mprod[j][59:30];
      d_pl[j]   <= d_nx[j];
      d_term[j] <= dprod[j][64:34];
    end
    fv      <= $signed(f_val);
    fv_sat  <= f_sat;
    out_tag <= fin.tag;
  end
endmodule

// ===== src/trz_atan.sv =====
// Arctangent unit: normalize, 30-stage CORDIC vectoring, round to Q.FRAC_BITS.
`timescale 1ns / 1ps
module trz_atan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [trz_pkg::XW-1:0]   x,
  input  trz_pkg::pt_tag_t                in_tag,
  output logic                            out_valid,
  output logic signed [trz_pkg::FW-1:0]   fv,
  output logic                            fv_sat,
  output trz_pkg::pt_tag_t                out_tag
);
  import trz_pkg::*;

  logic [XW-1:0]      xu, ax;
  logic [FW-1:0]      mx;
  logic [5:0]         sh_next;
  logic               c1_v, c1_neg;
  logic [FW-1:0]      c1_ax;
  logic [5:0]         c1_sh;
  pt_tag_t            c1_tag;

  logic               cv   [CORDIC_STEPS+1];
  logic               cneg [CORDIC_STEPS+1];
  pt_tag_t            ctag [CORDIC_STEPS+1];
  logic signed [63:0] cx   [CORDIC_STEPS+1];
  logic signed [63:0] cy   [CORDIC_STEPS+1];
  logic signed [31:0] cz   [CORDIC_STEPS+1];
  logic signed [63:0] nx   [CORDIC_STEPS];
  logic signed [63:0] ny   [CORDIC_STEPS];
  logic signed [31:0] nz   [CORDIC_STEPS];

  logic signed [31:0] zf;
  logic [31:0]        mz, rz;
  logic signed [FW-1:0] zs;

  assign xu = x;
  assign ax = xu[XW-1] ? (~xu + 1'b1) : xu;
  assign mx = (ax[FW-1:0] >= (48'd1 << FRAC_BITS)) ? ax[FW-1:0] : (48'd1 << FRAC_BITS);

  // left shift that puts the larger of |x| and one at bit 59
  always_comb begin
    sh_next = 6'd35;
    for (int i = 0; i < FW - FRAC_BITS; i++) begin
      if (mx[FRAC_BITS + i]) sh_next = 6'(35 - i);
    end
  end

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!cy[i][63]) begin
        nx[i] = cx[i] + (cy[i] >>> i);
        ny[i] = cy[i] - (cx[i] >>> i);
        nz[i] = cz[i] + $signed(32'(ATAN_TAB[i]));
      end else begin
        nx[i] = cx[i] - (cy[i] >>> i);
        ny[i] = cy[i] + (cx[i] >>> i);
        nz[i] = cz[i] - $signed(32'(ATAN_TAB[i]));
      end
    end
  end

  assign zf = cz[CORDIC_STEPS];
  assign mz = zf[31] ? 32'(-zf) : 32'(zf);
  assign rz = (mz + 32'd32) >> 6;
  assign zs = zf[31] ? -$signed(48'(rz)) : $signed(48'(rz));

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      for (int i = 0; i <= CORDIC_STEPS; i++) cv[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c1_v  <= in_valid;
      cv[0] <= c1_v;
      for (int i = 0; i < CORDIC_STEPS; i++) cv[i+1] <= cv[i];
      out_valid <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    c1_ax   <= ax[FW-1:0];
    c1_sh   <= sh_next;
    c1_neg  <= xu[XW-1];
    c1_tag  <= in_tag;
    cx[0]   <= $signed(64'd1 << (FRAC_BITS + int'(c1_sh)));
    cy[0]   <= $signed(64'(c1_ax) << c1_sh);
    cz[0]   <= '0;
    cneg[0] <= c1_neg;
    ctag[0] <= c1_tag;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      cx[i+1]   <= nx[i];
      cy[i+1]   <= ny[i];
      cz[i+1]   <= nz[i];
      cneg[i+1] <= cneg[i];
      ctag[i+1] <= ctag[i];
    end
    fv      <= cneg[CORDIC_STEPS] ? -zs : zs;
    fv_sat  <= 1'b0;
    out_tag <= ctag[CORDIC_STEPS];
  end
endmodule

// ===== src/trz_acc.sv =====
// Saturating weighted accumulator and final scaling by the step width.
`timescale 1ns / 1ps
module trz_acc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clr,
  input  logic                            fv_valid,
  input  logic signed [trz_pkg::FW-1:0]   fv,
  input  logic                            fv_sat,
  input  trz_pkg::pt_tag_t                fv_tag,
  input  logic [30:0]                     step_width,
  output logic                            res_valid,
  output logic signed [63:0]              estimate,
  output logic                            saturated
);
  import trz_pkg::*;

  logic signed [63:0] acc, acc_next;
  logic               acc_sat, acc_sat_next;
  logic signed [64:0] addv, sum;
  logic               clip;
  logic               p1_v, p1_neg, p1_sat;
  logic [63:0]        p1_mag;
  logic               p2_v, p2_neg, p2_sat;
  logic [62:0]        pp_lo, pp_hi;
  logic [95:0]        prod;
  logic [70:0]        v;
  logic               big;
  logic [63:0]        mag;

  assign addv = fv_tag.w2 ? (65'(fv) <<< 1) : 65'(fv);
  assign sum  = 65'(acc) + addv;

  always_comb begin
    clip = 1'b0;
    acc_next = sum[63:0];
    if (sum > $signed({1'b0, ACC_MAX})) begin
      clip = 1'b1;
      acc_next = $signed(ACC_MAX);
    end else if (sum < -$signed({1'b0, ACC_MAX})) begin
      clip = 1'b1;
      acc_next = -$signed(ACC_MAX);
    end
    acc_sat_next = acc_sat | fv_sat | clip;
  end

  // rounding half up at bit FRAC_BITS, one extra bit halves the doubled sum
  assign prod = {1'b0, pp_hi, 32'b0} + 96'(pp_lo) + (96'd1 << FRAC_BITS);
  assign v    = prod[95:FRAC_BITS+1];
  assign big  = v > 71'(ACC_MAX);
  assign mag  = big ? ACC_MAX : v[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_sat   <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (clr) begin
        acc     <= '0;
        acc_sat <= 1'b0;
      end else if (fv_valid) begin
        acc     <= acc_next;
        acc_sat <= acc_sat_next;
      end
      p1_v      <= fv_valid & fv_tag.last;
      p2_v      <= p1_v;
      res_valid <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_mag    <= acc_next[63] ? 64'(-acc_next) : 64'(acc_next);
    p1_neg    <= acc_next[63];
    p1_sat    <= acc_sat_next;
    pp_lo     <= p1_mag[31:0] * step_width;
    pp_hi     <= p1_mag[63:32] * step_width;
    p2_neg    <= p1_neg;
    p2_sat    <= p1_sat;
    estimate  <= p2_neg ? -$signed(mag) : $signed(mag);
    saturated <= p2_sat | big;
  end
endmodule

// ===== src/trapezoid_rule_integrator.sv =====
// Top level: job sequencer, integrand units and result path.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Composite trapezoid integrator. A job is taken when start is high and busy
// is low; busy stays high until its result is shown. The sequencer feeds one
// sample per cycle into the selected integrand pipeline (left end, right end,
// then the interior points a + i*h), so a job with num_traps n (clamped to
// MAX_COUNT, taken as at least 1) issues n + 1 samples. done rises after the
// last sample has passed the integrand pipeline, whose depth is 2 for the
// square, 33 for the exponential and 33 for the arctangent, and the final
// multiply by the step width in the accumulator's p1, p2 and output
// registers. busy drops in the cycle after done. The result sits on
// estimate/saturated for exactly one cycle with done high; the receiver
// cannot stall it. func_select may be written only while busy is low; code 3
// returns zero with done high, through the ST_ZERO state and the zero_done
// register.
module trapezoid_rule_integrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] lower_limit,
  input  logic signed [31:0] upper_limit,
  input  logic [30:0]        step_width,
  input  logic [16:0]        num_traps,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  output logic               done,
  output logic signed [63:0] estimate,
  output logic               saturated
);
  import trz_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LEFT  = 6'b000010,
    ST_RIGHT = 6'b000100,
    ST_INNER = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_ZERO  = 6'b100000
  } seq_state_t;

  seq_state_t            state, state_next;
  logic [1:0]            func_select;
  logic signed [XW-1:0]  a_r, b_r, xr, xr_next;
  logic [30:0]           h_r;
  logic [16:0]           cnt, cnt_next, ncl;
  logic                  pt_valid, pt_valid_next;
  logic signed [XW-1:0]  pt_x, pt_x_next;
  pt_tag_t               pt_tag, pt_tag_next;
  logic                  zero_done, zero_done_next;
  logic                  accept;

  logic                  sq_v, ex_v, at_v;
  logic signed [FW-1:0]  sq_f, ex_f, at_f;
  logic                  sq_s, ex_s, at_s;
  pt_tag_t               sq_t, ex_t, at_t;
  logic                  f_v, f_s;
  logic signed [FW-1:0]  f_val;
  pt_tag_t               f_t;
  logic                  acc_v, acc_sat;
  logic signed [63:0]    acc_est;

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;
  assign ncl    = (num_traps > 17'(MAX_COUNT)) ? 17'(MAX_COUNT) : num_traps;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    xr_next        = xr;
    pt_valid_next  = 1'b0;
    pt_x_next      = pt_x;
    pt_tag_next    = '0;
    zero_done_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (func_select == 2'd3) ? ST_ZERO : ST_LEFT;
          cnt_next   = (ncl > 17'd1) ? ncl - 17'd1 : 17'd0;
        end
      end
      ST_LEFT: begin
        pt_valid_next = 1'b1;
        pt_x_next     = a_r;
        state_next    = ST_RIGHT;
      end
      ST_RIGHT: begin
        pt_valid_next    = 1'b1;
        pt_x_next        = b_r;
        pt_tag_next.last = (cnt == 17'd0);
        xr_next          = a_r + $signed(XW'(h_r));
        state_next       = (cnt == 17'd0) ? ST_WAIT : ST_INNER;
      end
      ST_INNER: begin
        pt_valid_next    = 1'b1;
        pt_x_next        = xr;
        pt_tag_next.w2   = 1'b1;
        pt_tag_next.last = (cnt == 17'd1);
        xr_next          = xr + $signed(XW'(h_r));
        cnt_next         = cnt - 17'd1;
        if (cnt == 17'd1) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (acc_v || zero_done) state_next = ST_IDLE;
      end
      ST_ZERO: begin
        zero_done_next = 1'b1;
        state_next     = ST_WAIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      func_select <= FN_SQUARE;
      pt_valid    <= 1'b0;
      zero_done   <= 1'b0;
    end else begin
      state     <= state_next;
      pt_valid  <= pt_valid_next;
      zero_done <= zero_done_next;
      if (cfg_we) func_select <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    xr     <= xr_next;
    pt_x   <= pt_x_next;
    pt_tag <= pt_tag_next;
    if (accept) begin
      a_r <= XW'(lower_limit);
      b_r <= XW'(upper_limit);
      h_r <= step_width;
    end
  end

  trz_sq u_sq (
    .clk(clk), .rst(rst), .in_valid(pt_valid && func_select == FN_SQUARE),
    .x(pt_x), .in_tag(pt_tag), .out_valid(sq_v), .fv(sq_f), .fv_sat(sq_s),
    .out_tag(sq_t)
  );

  trz_exp u_exp (
    .clk(clk), .rst(rst), .in_valid(pt_valid && func_select == FN_EXP),
    .x(pt_x), .in_tag(pt_tag), .out_valid(ex_v), .fv(ex_f), .fv_sat(ex_s),
    .out_tag(ex_t)
  );

  trz_atan u_atan (
    .clk(clk), .rst(rst), .in_valid(pt_valid && func_select == FN_ATAN),
    .x(pt_x), .in_tag(pt_tag), .out_valid(at_v), .fv(at_f), .fv_sat(at_s),
    .out_tag(at_t)
  );

  always_comb begin
    f_v = sq_v; f_val = sq_f; f_s = sq_s; f_t = sq_t;
    case (func_select)
      FN_EXP:  begin f_v = ex_v; f_val = ex_f; f_s = ex_s; f_t = ex_t; end
      FN_ATAN: begin f_v = at_v; f_val = at_f; f_s = at_s; f_t = at_t; end
      default: begin f_v = sq_v; f_val = sq_f; f_s = sq_s; f_t = sq_t; end
    endcase
  end

  trz_acc u_acc (
    .clk(clk), .rst(rst), .clr(accept), .fv_valid(f_v), .fv(f_val),
    .fv_sat(f_s), .fv_tag(f_t), .step_width(h_r), .res_valid(acc_v),
    .estimate(acc_est), .saturated(acc_sat)
  );

  assign done      = acc_v | zero_done;
  assign estimate  = zero_done ? 64'sd0 : acc_est;
  assign saturated = zero_done ? 1'b0 : acc_sat;

  `ASSERT_IMPLY(a_done_in_job, clk, rst, done, busy)
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_one_beat, clk, rst, done, !done)
  `ASSERT_IMPLY(a_pt_in_job, clk, rst, pt_valid, busy)
endmodule

// ===== tb/trz_checker.sv =====
// Checker for the trapezoid integrator: job predictor and result compare.
`timescale 1ns / 1ps
module trz_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] lower_limit,
  input  logic signed [31:0] upper_limit,
  input  logic [30:0]        step_width,
  input  logic [16:0]        num_traps,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               done,
  input  logic signed [63:0] estimate,
  input  logic               saturated,
  output int                 errors,
  output int                 pending
);
  import trz_pkg::*;

  typedef struct {
    longint est;
    bit     sat;
  } integral_t;

  localparam longint FMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint AMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  integral_t  expected_q[$];
  logic [1:0] integrand;

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // (p + half) >> s, clipped to lim
  function automatic logic [63:0] round_shift(input logic [127:0] p, input int s,
                                              input logic [63:0] lim, inout bit sat);
    logic [128:0] t;
    t = ({1'b0, p} + (129'd1 << (s - 1))) >> s;
    if (t > {65'd0, lim}) begin
      sat = 1;
      return lim;
    end
    return t[63:0];
  endfunction

  function automatic longint f_square(input longint x, inout bit sat);
    logic [127:0] m;
    m = {64'd0, mag(x)};
    return longint'(round_shift(m * m, FRAC_BITS, 64'(FMAX), sat));
  endfunction

  function automatic longint f_exp(input longint x, inout bit sat);
    longint lim, x30, k, r, sh;
    logic [63:0] sum, term, v;
    lim = longint'(32) <<< FRAC_BITS;
    if (x > lim) begin
      sat = 1;
      return FMAX;
    end
    if (x < -lim) return 0;
    x30 = x * (longint'(1) <<< (30 - FRAC_BITS));
    k = x30 / longint'(LN2_Q30);
    r = x30 - k * longint'(LN2_Q30);
    if (r < 0) begin
      r += longint'(LN2_Q30);
      k--;
    end
    sum = 64'd1 << 30;
    term = sum;
    for (int n = 1; n <= EXP_TERMS; n++) begin
      term = ((term * 64'(r)) >> 30) / 64'(n);
      sum += term;
    end
    sh = k - (30 - FRAC_BITS);
    if (sh >= 0) begin
      if (sh > 16) begin
        sat = 1;
        return FMAX;
      end
      v = sum << sh;
      if (v > 64'(FMAX)) begin
        sat = 1;
        return FMAX;
      end
      return longint'(v);
    end
    sh = -sh;
    if (sh > 62) return 0;
    return longint'((sum + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint f_atan(input longint x);
    logic [63:0] ax, one, m, mz;
    longint cx, cy, z, dx, dy;
    ax = mag(x);
    one = 64'd1 << FRAC_BITS;
    m = ax > one ? ax : one;
    while (m < (64'd1 << 59)) begin
      m <<= 1;
      ax <<= 1;
      one <<= 1;
    end
    cx = longint'(one);
    cy = longint'(ax);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        z += longint'(ATAN_TAB[i]);
      end else begin
        cx -= dx;
        cy += dy;
        z -= longint'(ATAN_TAB[i]);
      end
    end
    mz = (mag(z) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    z = z < 0 ? -longint'(mz) : longint'(mz);
    return x < 0 ? -z : z;
  endfunction

  function automatic longint integrand_at(input logic [1:0] sel, input longint x,
                                          inout bit sat);
    case (sel)
      FN_SQUARE: return f_square(x, sat);
      FN_EXP:    return f_exp(x, sat);
      default:   return f_atan(x);
    endcase
  endfunction

  function automatic integral_t trapezoid_sum(input logic [1:0] sel, input longint a,
                                              input longint b, input logic [30:0] h,
                                              input logic [16:0] cnt);
    integral_t    res;
    longint       acc, fx, n;
    logic [127:0] p;
    logic [63:0]  v;
    bit           sat;
    sat = 0;
    res.est = 0;
    res.sat = 0;
    n = cnt > MAX_COUNT ? MAX_COUNT : cnt;
    if (sel > FN_ATAN) return res;
    acc = integrand_at(sel, a, sat) + integrand_at(sel, b, sat);
    for (longint i = 1; i < n; i++) begin
      fx = 2 * integrand_at(sel, a + i * longint'(h), sat);
      if (fx > 0 && acc > AMAX - fx) begin
        sat = 1;
        acc = AMAX;
      end else if (fx < 0 && acc < -AMAX - fx) begin
        sat = 1;
        acc = -AMAX;
      end else begin
        acc += fx;
      end
    end
    p = {64'd0, mag(acc)} * {97'd0, h};
    v = round_shift(p, FRAC_BITS + 1, 64'(AMAX), sat);
    res.est = acc < 0 ? -longint'(v) : longint'(v);
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    integral_t want;
    if (rst) begin
      integrand <= FN_SQUARE;
      expected_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (start && !busy)
        expected_q.push_back(trapezoid_sum(integrand, lower_limit, upper_limit,
                                           step_width, num_traps));
      if (cfg_we) integrand <= cfg_data;
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", estimate, 0);
        end else begin
          want = expected_q.pop_front();
          if (estimate !== want.est) report_mismatch("estimate", estimate, want.est);
          if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

// ===== tb/tb_trapezoid_rule_integrator.sv =====
// Testbench top: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_trapezoid_rule_integrator;
  import trz_pkg::*;

  localparam logic [1:0] FN_NONE = 2'd3;
  localparam int LIMIT = 12000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic signed [31:0] lower_limit = 0;
  logic signed [31:0] upper_limit = 0;
  logic [30:0]        step_width = 0;
  logic [16:0]        num_traps = 0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_data = 0;
  logic               done;
  logic signed [63:0] estimate;
  logic               saturated;
  int                 errors, pending;
  int                 cycles = 0;
  int                 gap_pct = 0;

  always #2 clk = ~clk;

  trapezoid_rule_integrator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lower_limit(lower_limit), .upper_limit(upper_limit), .step_width(step_width),
    .num_traps(num_traps), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .estimate(estimate), .saturated(saturated)
  );

  trz_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lower_limit(lower_limit), .upper_limit(upper_limit), .step_width(step_width),
    .num_traps(num_traps), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .estimate(estimate), .saturated(saturated),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_trapezoid_rule_integrator: done, errors");
      $finish;
    end
  end

  task automatic send_job(input logic [31:0] a, input logic [31:0] b,
                          input logic [30:0] h, input logic [16:0] n);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    lower_limit <= a;
    upper_limit <= b;
    step_width <= h;
    num_traps <= n;
    do @(posedge clk); while (busy);
  endtask

  // drain all outstanding jobs, then write the integrand select
  task automatic set_integrand(input logic [1:0] sel);
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= sel;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_x();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($urandom_range(0, 32'd8 << 24)) - (32'd4 << 24);
  endfunction

  function automatic logic [30:0] pick_step();
    if ($urandom_range(0, 4) == 0) return 31'($urandom);
    return 31'($urandom_range(0, 1 << 23));
  endfunction

  function automatic logic [16:0] pick_count();
    case ($urandom_range(0, 49))
      0:       return 17'd0;
      1:       return 17'($urandom);
      2, 3:    return 17'($urandom_range(1, 1024));
      default: return 17'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    logic [1:0] sel;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    gap_pct = 22;
    for (int s = FN_SQUARE; s <= FN_ATAN; s++) begin
      set_integrand(2'(s));
      send_job(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd1);
      send_job(32'd0, 32'd0, 31'd0, 17'd0);
      send_job(-(32'd2 << 24), 32'd2 << 24, 31'd1 << 23, 17'd8);
      send_job(32'd1 << 29, -(32'd1 << 29), 31'd1 << 24, 17'd2);
    end
    send_job(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 17'h1FFFF);
    set_integrand(FN_NONE);
    send_job(32'h1234_5678, 32'h8765_4321, 31'h7FFF_FFFF, 17'd5);
    for (int i = 0; i < 580; i++) begin
      if (i == 193) gap_pct = 53;
      if (i == 386) gap_pct = 0;
      if (i % 20 == 0) begin
        sel = $urandom_range(0, 9) == 0 ? FN_NONE : 2'($urandom_range(0, 2));
        set_integrand(sel);
      end
      send_job(pick_x(), pick_x(), pick_step(), pick_count());
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_trapezoid_rule_integrator: done, clean");
    end else begin
      $display("tb_trapezoid_rule_integrator: done, errors");
    end
    $finish;
  end
endmodule
